// ===== rtl/lcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants of the LBA to CHS request unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lcs_pkg;

    localparam int WINDOW_BYTES_DEF = 65536;
    localparam int LBA_W            = 64;
    localparam int CNT_W            = 8;
    localparam int SPT_W            = 6;
    localparam int HDS_W            = 9;
    localparam int SB_W             = 13;
    localparam int LOW_W            = 32;
    localparam int ADDR_W           = 6;
    localparam int DATA_W           = 64;

    localparam logic [7:0] OP_CHS_READ = 8'h02;
    localparam logic [7:0] OP_EXT_READ = 8'h42;

    typedef enum logic [2:0] {
        REG_SPT   = 3'd0,
        REG_HDS   = 3'd1,
        REG_SB    = 3'd2,
        REG_TOTAL = 3'd3,
        REG_DRIVE = 3'd4,
        REG_EXT   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic             kind;
        logic [LBA_W-1:0] lba;
        logic [CNT_W-1:0] sector_count;
    } req_t;

    typedef struct packed {
        logic             accepted;
        logic [15:0]      ax_word;
        logic [15:0]      cx_word;
        logic [15:0]      dx_word;
        logic [9:0]       cylinder;
        logic [7:0]       head_index;
        logic [5:0]       sector_number;
        logic [LBA_W-1:0] packet_lba;
        logic [CNT_W-1:0] packet_count;
    } res_t;

    typedef struct packed {
        logic [SPT_W-1:0] sectors_per_track;
        logic [HDS_W-1:0] head_count;
        logic [SB_W-1:0]  sector_bytes;
        logic [LBA_W-1:0] total_sectors;
        logic [7:0]       drive_number;
        logic             use_extended;
    } cfg_t;

    typedef struct packed {
        logic             kind;
        logic [LBA_W-1:0] lba;
        logic [CNT_W-1:0] cnt;
        logic             ok;
    } side_t;

endpackage

`default_nettype wire

// ===== rtl/lcs_div.sv =====
// ----------------------------------------------------------------------------
// lcs_div
// Pipelined restoring divider, a few quotient bits per stage, with a
// sideband tag that travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_div #(
    parameter int DW  = 32,
    parameter int VW  = 6,
    parameter int BPS = 4,
    parameter int TW  = 1
) (
    input  wire logic          clk,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    input  wire logic [TW-1:0] tag_in,
    output logic      [DW-1:0] quotient,
    output logic      [VW-1:0] remainder,
    output logic      [TW-1:0] tag_out
);

    localparam int NSTG = DW / BPS;

    logic [VW-1:0] rem_reg  [NSTG];
    logic [DW-1:0] word_reg [NSTG];
    logic [TW-1:0] tag_reg  [NSTG];

    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        logic [VW-1:0] rem_in;
        logic [DW-1:0] word_in;
        logic [TW-1:0] tag_fwd;
        logic [VW-1:0] rem_next;
        logic [DW-1:0] word_next;
        logic [TW-1:0] tag_next;

        if (g == 0)
        begin : g_first
            assign rem_in  = '0;
            assign word_in = dividend;
            assign tag_fwd = tag_in;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[g-1];
            assign word_in = word_reg[g-1];
            assign tag_fwd = tag_reg[g-1];
        end

        always_comb
        begin
            logic [VW:0] trial;
            rem_next  = rem_in;
            word_next = word_in;
            tag_next  = tag_fwd;
            for (int b = 0; b < BPS; b++)
            begin
                trial     = {rem_next, word_next[DW-1]};
                word_next = {word_next[DW-2:0], 1'b0};
                if (trial >= {1'b0, divisor})
                begin
                    rem_next     = VW'(trial - {1'b0, divisor});
                    word_next[0] = 1'b1;
                end
                else
                begin
                    rem_next = trial[VW-1:0];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g]  <= rem_next;
            word_reg[g] <= word_next;
            tag_reg[g]  <= tag_next;
        end
    end

    assign quotient  = word_reg[NSTG-1];
    assign remainder = rem_reg[NSTG-1];
    assign tag_out   = tag_reg[NSTG-1];

endmodule

`default_nettype wire

// ===== rtl/lcs_check.sv =====
// ----------------------------------------------------------------------------
// lcs_check
// Two-stage request check: count limit against the transfer window and
// end of request against the disk size.
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_check #(
    parameter int WINDOW_BYTES = lcs_pkg::WINDOW_BYTES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 valid_in,
    input  wire lcs_pkg::req_t        request,
    input  wire lcs_pkg::cfg_t        cfg,
    output logic                      valid_out,
    output lcs_pkg::side_t            side
);
    import lcs_pkg::*;

    localparam int PROD_W = CNT_W + 1 + SB_W;

    logic              a_valid_reg, a_valid_next;
    logic              a_kind_reg;
    logic [LBA_W-1:0]  a_lba_reg;
    logic [CNT_W-1:0]  a_cnt_reg;
    logic [LBA_W:0]    a_end_reg, a_end_next;
    logic              a_cnt_ok_reg, a_cnt_ok_next;
    logic              b_valid_reg;
    side_t             b_side_reg, b_side_next;
    logic [PROD_W-1:0] prod;

    // (count + 1) * sector size must fit in the window
    assign prod = PROD_W'({1'b0, request.sector_count} + 9'd1) * PROD_W'(cfg.sector_bytes);
    assign a_cnt_ok_next = (request.sector_count != '0) && (cfg.sector_bytes != '0)
                           && (prod <= PROD_W'(WINDOW_BYTES));
    assign a_end_next    = {1'b0, request.lba} + (LBA_W+1)'(request.sector_count);
    assign a_valid_next  = valid_in;

    always_comb
    begin
        b_side_next.kind = a_kind_reg;
        b_side_next.lba  = a_lba_reg;
        b_side_next.cnt  = a_cnt_reg;
        b_side_next.ok   = a_cnt_ok_reg && !a_end_reg[LBA_W]
                           && (a_end_reg[LBA_W-1:0] <= cfg.total_sectors);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_kind_reg   <= request.kind;
        a_lba_reg    <= request.lba;
        a_cnt_reg    <= request.sector_count;
        a_end_reg    <= a_end_next;
        a_cnt_ok_reg <= a_cnt_ok_next;
        b_side_reg   <= b_side_next;
    end

    assign valid_out = b_valid_reg;
    assign side      = b_side_reg;

endmodule

`default_nettype wire

// ===== rtl/disk_request_lba_to_chs_unit.sv =====
// ----------------------------------------------------------------------------
// disk_request_lba_to_chs_unit
// Checks disk requests and packs INT 13h CHS or extended register words.
//
// A request is taken when start is high; busy is always low, so a new
// request may be issued every cycle. Each request gives one result,
// shown on result for one cycle with result_valid high. Throughput is
// one request per cycle. A request runs through the two pipelined
// dividers (sectors per track, then heads), eight stages each at four
// quotient bits per stage, then the output register; the count and end
// checks run in parallel. Geometry and limits are set through the APB
// port, 64-bit registers at byte offsets 8*i; the user must change them
// only while no request is in flight, which the block does not enforce.
// Reset clears the pipeline valid bits and loads the default geometry.
// The receiver cannot stall: each result is taken in the cycle shown.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_request_lba_to_chs_unit #(
    parameter int WINDOW_BYTES = lcs_pkg::WINDOW_BYTES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire lcs_pkg::req_t                request,
    output logic                              result_valid,
    output lcs_pkg::res_t                     result,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [lcs_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lcs_pkg::DATA_W-1:0]   pwdata,
    output logic      [lcs_pkg::DATA_W-1:0]   prdata,
    output logic                              pready
);
    import lcs_pkg::*;

    localparam int BPS     = 4;
    localparam int DIV_LAT = LOW_W / BPS;
    localparam int CHK_LAT = 2;
    localparam int DLY     = 2 * DIV_LAT - CHK_LAT;

    cfg_t             cfg_reg, cfg_next;
    reg_idx_t         idx;
    logic             wr_en;
    logic             chk_valid;
    side_t            chk_side;
    logic             dly_valid_reg [DLY];
    side_t            dly_side_reg  [DLY];
    logic [SPT_W-1:0] spt_eff;
    logic [HDS_W-1:0] hds_eff;
    logic [LOW_W-1:0] q1, q2;
    logic [SPT_W-1:0] r1, r1_tag;
    logic [HDS_W-1:0] r2;
    logic [SPT_W-1:0] r2_unused_tag;
    logic             out_valid_reg;
    res_t             out_reg, out_next;
    side_t            sd;
    logic [5:0]       sec;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_SPT:   cfg_next.sectors_per_track = pwdata[SPT_W-1:0];
                REG_HDS:   cfg_next.head_count        = pwdata[HDS_W-1:0];
                REG_SB:    cfg_next.sector_bytes      = pwdata[SB_W-1:0];
                REG_TOTAL: cfg_next.total_sectors     = pwdata;
                REG_DRIVE: cfg_next.drive_number      = pwdata[7:0];
                REG_EXT:   cfg_next.use_extended      = pwdata[0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SPT:   prdata = DATA_W'(cfg_reg.sectors_per_track);
            REG_HDS:   prdata = DATA_W'(cfg_reg.head_count);
            REG_SB:    prdata = DATA_W'(cfg_reg.sector_bytes);
            REG_TOTAL: prdata = cfg_reg.total_sectors;
            REG_DRIVE: prdata = DATA_W'(cfg_reg.drive_number);
            REG_EXT:   prdata = DATA_W'(cfg_reg.use_extended);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sectors_per_track <= SPT_W'(63);
            cfg_reg.head_count        <= HDS_W'(16);
            cfg_reg.sector_bytes      <= SB_W'(512);
            cfg_reg.total_sectors     <= '0;
            cfg_reg.drive_number      <= 8'd128;
            cfg_reg.use_extended      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lcs_check #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (start),
        .request   (request),
        .cfg       (cfg_reg),
        .valid_out (chk_valid),
        .side      (chk_side)
    );

    // zero geometry acts as one
    assign spt_eff = (cfg_reg.sectors_per_track == '0) ? SPT_W'(1) : cfg_reg.sectors_per_track;
    assign hds_eff = (cfg_reg.head_count == '0) ? HDS_W'(1) : cfg_reg.head_count;

    lcs_div #(
        .DW (LOW_W), .VW (SPT_W), .BPS (BPS), .TW (SPT_W)
    ) u_div_spt (
        .clk       (clk),
        .dividend  (request.lba[LOW_W-1:0]),
        .divisor   (spt_eff),
        .tag_in    ('0),
        .quotient  (q1),
        .remainder (r1),
        .tag_out   (r2_unused_tag)
    );

    lcs_div #(
        .DW (LOW_W), .VW (HDS_W), .BPS (BPS), .TW (SPT_W)
    ) u_div_hds (
        .clk       (clk),
        .dividend  (q1),
        .divisor   (hds_eff),
        .tag_in    (r1 | r2_unused_tag),
        .quotient  (q2),
        .remainder (r2),
        .tag_out   (r1_tag)
    );

    for (genvar g = 0; g < DLY; g++) begin : g_dly
        if (g == 0)
        begin : g_head
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dly_valid_reg[g] <= 1'b0;
                else
                    dly_valid_reg[g] <= chk_valid;
            end

            always_ff @(posedge clk)
            begin
                dly_side_reg[g] <= chk_side;
            end
        end
        else
        begin : g_tail
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dly_valid_reg[g] <= 1'b0;
                else
                    dly_valid_reg[g] <= dly_valid_reg[g-1];
            end

            always_ff @(posedge clk)
            begin
                dly_side_reg[g] <= dly_side_reg[g-1];
            end
        end
    end

    assign sd  = dly_side_reg[DLY-1];
    assign sec = SPT_W'(r1_tag + SPT_W'(1));

    always_comb
    begin
        out_next = '0;
        if (sd.ok)
        begin
            out_next.accepted = 1'b1;
            if (cfg_reg.use_extended)
            begin
                out_next.ax_word      = {OP_EXT_READ + 8'(sd.kind), 8'h00};
                out_next.dx_word      = {8'h00, cfg_reg.drive_number};
                out_next.packet_lba   = sd.lba;
                out_next.packet_count = sd.cnt;
            end
            else
            begin
                out_next.ax_word       = {OP_CHS_READ + 8'(sd.kind), sd.cnt};
                out_next.cx_word       = {q2[7:0], q2[9:8], sec};
                out_next.dx_word       = {r2[7:0], cfg_reg.drive_number};
                out_next.cylinder      = q2[9:0];
                out_next.head_index    = r2[7:0];
                out_next.sector_number = sec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= dly_valid_reg[DLY-1];
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire
